>>> design/bard_pkg.sv
// Shared codes and types for the bus address range decoder.
`timescale 1ns / 1ps

package bard_pkg;

    // Input item modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Result outcome codes
    localparam logic [2:0] OC_READ_FWD   = 3'd0;
    localparam logic [2:0] OC_WRITE_FWD  = 3'd1;
    localparam logic [2:0] OC_READ_EMPTY = 3'd2;
    localparam logic [2:0] OC_WRITE_DROP = 3'd3;
    localparam logic [2:0] OC_ADDED      = 3'd4;
    localparam logic [2:0] OC_REJECTED   = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 2'd1;

    // Byte-wide data path
    localparam int unsigned DATA_W = 8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ADD  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    // Table write and read command from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctrl_t;

endpackage

>>> design/bard_table.sv
// Window table memory with fill count; slots fill in order and are freed only by reset.
`timescale 1ns / 1ps

module bard_table
    import bard_pkg::*;
#(
    parameter int MAX_WINDOWS    = 256,
    parameter int ADDR_BITS      = 16,
    parameter int DEVICE_ID_BITS = 8,
    parameter int IDX_W          = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
    parameter int CNT_W          = $clog2(MAX_WINDOWS + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tbl_ctrl_t                 ctrl,
    input  logic [ADDR_BITS-1:0]      wr_start,
    input  logic [ADDR_BITS-1:0]      wr_end,
    input  logic [DEVICE_ID_BITS-1:0] wr_target,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic [ADDR_BITS-1:0]      rd_start,
    output logic [ADDR_BITS-1:0]      rd_end,
    output logic [DEVICE_ID_BITS-1:0] rd_target,
    output logic [CNT_W-1:0]          count
);

    logic [ADDR_BITS-1:0]      start_mem  [MAX_WINDOWS];
    logic [ADDR_BITS-1:0]      end_mem    [MAX_WINDOWS];
    logic [DEVICE_ID_BITS-1:0] target_mem [MAX_WINDOWS];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // Advance the fill count on every stored window
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Write the new window into the first free slot
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            start_mem[count_reg[IDX_W-1:0]]  <= wr_start;
            end_mem[count_reg[IDX_W-1:0]]    <= wr_end;
            target_mem[count_reg[IDX_W-1:0]] <= wr_target;
        end
    end

    // Registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_start  <= start_mem[rd_idx];
            rd_end    <= end_mem[rd_idx];
            rd_target <= target_mem[rd_idx];
        end
    end

    assign count = count_reg;

endmodule

>>> design/bard_cmp.sv
// Shared range compare and offset subtract unit.
`timescale 1ns / 1ps

module bard_cmp
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [ADDR_BITS-1:0] lo,
    input  logic [ADDR_BITS-1:0] hi,
    output logic                 in_range,
    output logic [ADDR_BITS-1:0] offset
);

    // Check lo <= addr <= hi and take the distance from lo
    always_comb
    begin
        in_range = (addr >= lo) && (addr <= hi);
        offset   = addr - lo;
    end

endmodule

>>> design/bus_address_range_decoder.sv
// An add item is checked in the add state, then its result goes into the output register.
// An access scans the stored windows in order, one window per cycle through the shared
// compare unit while the output does not stall; it ends on the first hit or last window.
// Throughput: one item at a time; a new transfer comes in the cycle after the result load,
// so an access holds the block for its whole scan, plus any output stall.
// Reset clears the fill count, the sequencer, the output valid and both config registers.
`timescale 1ns / 1ps

module bus_address_range_decoder
    import bard_pkg::*;
#(
    parameter int MAX_WINDOWS    = 256,
    parameter int ADDR_BITS      = 16,
    parameter int DEVICE_ID_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // Input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic [ADDR_BITS-1:0]      addr,
    input  logic [ADDR_BITS-1:0]      range_end,
    input  logic [DEVICE_ID_BITS-1:0] device_id,
    input  logic [DATA_W-1:0]         write_data,
    input  logic                      final_flag,
    // Output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                outcome,
    output logic [DEVICE_ID_BITS-1:0] target_device,
    output logic [ADDR_BITS-1:0]      offset,
    output logic [DATA_W-1:0]         data_out,
    output logic                      final_out
);

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int OWN_W = (DEVICE_ID_BITS > DATA_W) ? DEVICE_ID_BITS : DATA_W;

    state_t                    state_reg, state_next;
    logic [1:0]                mode_reg;
    logic [ADDR_BITS-1:0]      addr_reg;
    logic [ADDR_BITS-1:0]      end_reg;
    logic [DEVICE_ID_BITS-1:0] id_reg;
    logic [DATA_W-1:0]         wdata_reg;
    logic                      fin_reg;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [DATA_W-1:0]         empty_reg;
    logic [DATA_W-1:0]         own_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [2:0]                outcome_reg, outcome_next;
    logic [DEVICE_ID_BITS-1:0] target_reg, target_next;
    logic [ADDR_BITS-1:0]      offset_reg, offset_next;
    logic [DATA_W-1:0]         data_reg, data_next;
    logic                      final_reg, final_next;

    tbl_ctrl_t                 tbl_ctrl;
    logic [ADDR_BITS-1:0]      rd_start;
    logic [ADDR_BITS-1:0]      rd_end;
    logic [DEVICE_ID_BITS-1:0] rd_target;
    logic [CNT_W-1:0]          count;

    logic [ADDR_BITS-1:0]      cmp_lo;
    logic [ADDR_BITS-1:0]      cmp_hi;
    logic                      cmp_hit;
    logic [ADDR_BITS-1:0]      cmp_offset;

    logic [OWN_W-1:0]          own_wide;
    logic [DEVICE_ID_BITS-1:0] own_cmp;
    logic                      in_xfer;
    logic                      can_load;
    logic                      more;
    logic                      hit;
    logic                      is_write;

    assign in_xfer  = in_valid && !in_stall;
    assign can_load = !out_valid_reg || !out_stall;
    assign more     = (idx_reg < count);
    assign hit      = pend_reg && cmp_hit;
    assign is_write = (mode_reg == MODE_WRITE);
    assign own_wide = OWN_W'(own_reg);
    assign own_cmp  = own_wide[DEVICE_ID_BITS-1:0];

    bard_table #(
        .MAX_WINDOWS    (MAX_WINDOWS),
        .ADDR_BITS      (ADDR_BITS),
        .DEVICE_ID_BITS (DEVICE_ID_BITS),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tbl_ctrl),
        .wr_start  (addr_reg),
        .wr_end    (end_reg),
        .wr_target (id_reg),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_start  (rd_start),
        .rd_end    (rd_end),
        .rd_target (rd_target),
        .count     (count)
    );

    // Feed the compare unit: order check when adding, window check when scanning
    assign cmp_lo = (state_reg == ST_ADD) ? addr_reg : rd_start;
    assign cmp_hi = (state_reg == ST_ADD) ? end_reg  : rd_end;

    bard_cmp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cmp (
        .addr     (addr_reg),
        .lo       (cmp_lo),
        .hi       (cmp_hi),
        .in_range (cmp_hit),
        .offset   (cmp_offset)
    );

    // Sequence the add and the priority scan
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        tbl_ctrl       = '0;
        out_valid_next = out_valid_reg && out_stall;
        outcome_next   = outcome_reg;
        target_next    = target_reg;
        offset_next    = offset_reg;
        data_next      = data_reg;
        final_next     = final_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = '0;
                    if (mode == MODE_ADD)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (mode == MODE_READ || mode == MODE_WRITE)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_ADD:
            begin
                if (can_load)
                begin
                    tbl_ctrl.wr_en = cmp_hit && (count != CNT_W'(MAX_WINDOWS));
                    out_valid_next = 1'b1;
                    outcome_next   = tbl_ctrl.wr_en ? OC_ADDED : OC_REJECTED;
                    target_next    = id_reg;
                    offset_next    = '0;
                    data_next      = '0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!can_load)
                begin
                    // Freeze the scan until the output register frees up
                    pend_next = pend_reg;
                end
                else if (hit && rd_target != own_cmp)
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = is_write ? OC_WRITE_FWD : OC_READ_FWD;
                    target_next    = rd_target;
                    offset_next    = cmp_offset;
                    data_next      = is_write ? wdata_reg : '0;
                    final_next     = fin_reg;
                    state_next     = ST_IDLE;
                end
                else if (hit || (!more && !pend_reg))
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = is_write ? OC_WRITE_DROP : OC_READ_EMPTY;
                    target_next    = '0;
                    offset_next    = '0;
                    data_next      = is_write ? '0 : empty_reg;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    // Issue the next window read
                    tbl_ctrl.rd_en = more;
                    pend_next      = more;
                    if (more)
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            empty_reg     <= '0;
            own_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_EMPTY_VALUE)
            begin
                empty_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_OWN_ID)
            begin
                own_reg <= cfg_data;
            end
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg  <= mode;
            addr_reg  <= addr;
            end_reg   <= range_end;
            id_reg    <= device_id;
            wdata_reg <= write_data;
            fin_reg   <= final_flag;
        end
        outcome_reg <= outcome_next;
        target_reg  <= target_next;
        offset_reg  <= offset_next;
        data_reg    <= data_next;
        final_reg   <= final_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign target_device = target_reg;
    assign offset        = offset_reg;
    assign data_out      = data_reg;
    assign final_out     = final_reg;

endmodule

>>> design/bard_checker.sv
// Port-level checks for the bus address range decoder, bound to the top level.
`timescale 1ns / 1ps

module bard_checker
    import bard_pkg::*;
#(
    parameter int ADDR_BITS      = 16,
    parameter int DEVICE_ID_BITS = 8
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [1:0]                mode,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [2:0]                outcome,
    input logic [DEVICE_ID_BITS-1:0] target_device,
    input logic [ADDR_BITS-1:0]      offset,
    input logic                      final_out
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome)
            && $stable(target_device) && $stable(offset))
    else $error("stalled result changed");

    // Drop an unused-mode item without going busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_NONE |=> !in_stall)
    else $error("unused mode made the block busy");

    // Go busy after any real item transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode != MODE_NONE |=> in_stall)
    else $error("block took an item without going busy");

    // Clear routing fields on an unmapped access
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OC_READ_EMPTY || outcome == OC_WRITE_DROP)
            |-> target_device == '0 && offset == '0 && !final_out)
    else $error("unmapped access carries routing fields");

endmodule

bind bus_address_range_decoder bard_checker #(
    .ADDR_BITS      (ADDR_BITS),
    .DEVICE_ID_BITS (DEVICE_ID_BITS)
) u_bard_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .target_device (target_device),
    .offset        (offset),
    .final_out     (final_out)
);
